@@ sv/u16u8_pkg.sv @@
package u16u8_pkg;

    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [5:0]  SURR_HI_TOP   = 6'b110110;

    localparam logic [20:0] LIM_1 = 21'h80;
    localparam logic [20:0] LIM_2 = 21'h800;
    localparam logic [20:0] LIM_3 = 21'h10000;

    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    // number of utf-8 bytes minus one
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } t_len;

    // work handed from the front to the back: an optional lone high surrogate
    // first, then an optional code point, then the string end flag
    typedef struct packed {
        logic        pre_v;
        logic [9:0]  pre_hi;
        logic        main_v;
        logic [20:0] main_cp;
        logic        last;
    } t_job;

    function automatic t_len enc_len(input logic [20:0] cp);
        t_len len;
        if (cp < LIM_1) begin
            len = LEN_1;
        end else if (cp < LIM_2) begin
            len = LEN_2;
        end else if (cp < LIM_3) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input t_len len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_1: b = cp[7:0];
            LEN_2: begin
                case (idx)
                    2'd0:    b = LEAD_2 | {3'b000, cp[10:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = LEAD_3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            LEN_4: begin
                case (idx)
                    2'd0:    b = LEAD_4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ sv/u16u8_front.sv @@
module u16u8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [15:0]      i_code_unit,
    input  logic             i_last_unit,
    input  logic             i_q_full,
    output logic             o_push,
    output u16u8_pkg::t_job  o_job
);
    import u16u8_pkg::*;

    logic       r_held;
    logic [9:0] r_held_hi;
    logic       n_held;
    logic [9:0] n_held_hi;
    logic       accept;
    logic       is_hi;
    logic       is_lo;
    t_job       job;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        is_hi = i_code_unit inside {[SURR_HI_FIRST:SURR_HI_LAST]};
        is_lo = i_code_unit inside {[SURR_LO_FIRST:SURR_LO_LAST]};
        job.pre_v   = 1'b0;
        job.pre_hi  = r_held_hi;
        job.main_v  = 1'b1;
        job.main_cp = {5'b00000, i_code_unit};
        job.last    = i_last_unit;
        n_held      = 1'b0;
        n_held_hi   = 10'h000;
        if (r_held && is_lo) begin
            job.main_cp = SUPP_BASE + {1'b0, r_held_hi, i_code_unit[9:0]};
        end else begin
            job.pre_v = r_held;
            if (is_hi && !i_last_unit) begin
                job.main_v = 1'b0;
                n_held     = 1'b1;
                n_held_hi  = i_code_unit[9:0];
            end
        end
    end

    assign o_push = accept && (job.pre_v || job.main_v);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= 1'b0;
            r_held_hi <= 10'h000;
        end else if (accept) begin
            r_held    <= n_held;
            r_held_hi <= n_held_hi;
        end
    end

endmodule

@@ sv/u16u8_queue.sv @@
module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u16u8_pkg::t_job  i_job,
    input  logic             i_pop,
    output u16u8_pkg::t_job  o_job,
    output logic             o_valid,
    output logic             o_full
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/u16u8_back.sv @@
module u16u8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u16u8_pkg::t_job  i_job,
    input  logic             i_job_valid,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_string_end
);
    import u16u8_pkg::*;

    typedef enum logic {
        PH_PRE,
        PH_MAIN
    } t_phase;

    t_job        r_job;
    logic        r_busy;
    t_phase      r_phase;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic        r_run_last;
    logic        r_string_end;

    logic [20:0] cur_cp;
    t_len        cur_len;
    logic        out_free;
    logic        fire;
    logic        final_byte;
    logic        item_end;
    logic        pop;

    always_comb begin
        if (r_phase == PH_PRE) begin
            cur_cp  = {5'b00000, SURR_HI_TOP, r_job.pre_hi};
            cur_len = LEN_3;
        end else begin
            cur_cp  = r_job.main_cp;
            cur_len = enc_len(r_job.main_cp);
        end
        out_free   = !r_out_valid || !i_out_stall;
        fire       = r_busy && out_free;
        final_byte = (r_idx == cur_len);
        // the prefix surrogate ends the item only if no code point follows
        item_end   = final_byte && ((r_phase == PH_MAIN) || !r_job.main_v);
        pop        = i_job_valid && (!r_busy || (fire && item_end));
    end

    assign o_pop        = pop;
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_string_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_MAIN;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= fire;
            end
            if (fire) begin
                r_byte       <= enc_byte(cur_cp, cur_len, r_idx);
                r_run_last   <= item_end;
                r_string_end <= item_end && r_job.last;
                if (!final_byte) begin
                    r_idx <= r_idx + 2'd1;
                end else if (!item_end) begin
                    r_phase <= PH_MAIN;
                    r_idx   <= 2'd0;
                end
            end
            if (pop) begin
                r_job   <= i_job;
                r_phase <= i_job.pre_v ? PH_PRE : PH_MAIN;
                r_idx   <= 2'd0;
                r_busy  <= 1'b1;
            end else if (fire && item_end) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

@@ sv/utf16_to_utf8_transcoder.sv @@
// each item passes the job queue, then the back's job and output registers
// throughput: one byte per cycle on the output unless stalled; an item causes
// 1 to 6 bytes, and a held high surrogate causes none
// the input stalls only when the job queue (QUEUE_DEPTH entries) is full
// reset clears the held surrogate, the queue and the output valid
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_string_end
);
    import u16u8_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_job_valid  (q_valid),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule

@@ sv/u16u8_checker.sv @@
module u16u8_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_string_end
);

    // set when the next byte out must open a new sequence
    logic r_at_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            r_at_start <= o_run_last;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_run_last) && $stable(o_string_end))
        else $error("output item changed while stalled");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_end |-> o_run_last)
        else $error("string end without run last");

    a_ascii_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_byte[7] |-> o_run_last)
        else $error("single-byte code point not closing its item");

    a_lead_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_at_start |-> o_out_byte[7:6] != 2'b10)
        else $error("item opens with a continuation byte");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_byte   (o_out_byte),
    .o_run_last   (o_run_last),
    .o_string_end (o_string_end)
);

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam int RANDOM_UNITS = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PREDICTED    = -1;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } t_utf8_byte;

    // nbytes < 0: expected bytes come from the predictor
    typedef struct {
        logic [15:0] code;
        logic        last;
        int          nbytes;
        logic [47:0] bytes;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_code_unit = 16'h0000;
    logic        i_last_unit = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_string_end;

    utf16_to_utf8_transcoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_code_unit  (i_code_unit),
        .i_last_unit  (i_last_unit),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_stim_row directed_rows[23] = '{
        '{16'h0000, 1'b0, 1, 48'h0000_0000_0000},
        '{16'h007F, 1'b0, 1, 48'h7F00_0000_0000},
        '{16'h0080, 1'b0, 2, 48'hC280_0000_0000},
        '{16'h07FF, 1'b0, 2, 48'hDFBF_0000_0000},
        '{16'h0800, 1'b0, 3, 48'hE0A0_8000_0000},
        '{16'hFFFF, 1'b1, 3, 48'hEFBF_BF00_0000},
        // lowest and highest surrogate pairs
        '{16'hD800, 1'b0, 0, 48'h0000_0000_0000},
        '{16'hDC00, 1'b0, 4, 48'hF090_8080_0000},
        '{16'hDBFF, 1'b0, 0, 48'h0000_0000_0000},
        '{16'hDFFF, 1'b1, 4, 48'hF48F_BFBF_0000},
        // unpaired low, then high surrogate as the last unit
        '{16'hDC00, 1'b0, 3, 48'hEDB0_8000_0000},
        '{16'hD800, 1'b1, 3, 48'hEDA0_8000_0000},
        // held high followed by a high that ends the string
        '{16'hDBFF, 1'b0, 0, 48'h0000_0000_0000},
        '{16'hDBFF, 1'b1, 6, 48'hEDAF_BFED_AFBF},
        // held high followed by a plain unit
        '{16'hD800, 1'b0, 0, 48'h0000_0000_0000},
        '{16'h0041, 1'b0, 4, 48'hEDA0_8041_0000},
        '{16'hDBC0, 1'b0, PREDICTED, 48'h0},
        '{16'hD801, 1'b0, PREDICTED, 48'h0},
        '{16'hDFFF, 1'b0, PREDICTED, 48'h0},
        '{16'h1234, 1'b0, PREDICTED, 48'h0},
        '{16'hE000, 1'b0, PREDICTED, 48'h0},
        '{16'hD7FF, 1'b1, PREDICTED, 48'h0},
        '{16'h0000, 1'b1, 1, 48'h0000_0000_0000}
    };

    t_stim_row  stim_items[$];
    t_utf8_byte utf8_expected[$];
    t_utf8_byte unit_bytes[$];
    logic [9:0] held_hi_bits = 10'd0;
    logic       hi_pending = 1'b0;
    int         mismatches = 0;
    int         cycle_count = 0;

    function automatic void add_byte(input logic [7:0] b);
        t_utf8_byte ub;
        ub = '{data: b, run_last: 1'b0, string_end: 1'b0};
        unit_bytes.insert(unit_bytes.size(), ub);
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp < LIM_1) begin
            add_byte(cp[7:0]);
        end else if (cp < LIM_2) begin
            add_byte(LEAD_2 | {3'b000, cp[10:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end else if (cp < LIM_3) begin
            add_byte(LEAD_3 | {4'b0000, cp[15:12]});
            add_byte(CONT | {2'b00, cp[11:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end else begin
            add_byte(LEAD_4 | {5'b00000, cp[20:18]});
            add_byte(CONT | {2'b00, cp[17:12]});
            add_byte(CONT | {2'b00, cp[11:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end
    endfunction

    // fills unit_bytes with the utf-8 bytes one accepted code unit causes
    function automatic void transcode_unit(input logic [15:0] code, input logic last);
        logic       is_hi;
        logic       is_lo;
        t_utf8_byte tail;
        is_hi = (code >= SURR_HI_FIRST) && (code <= SURR_HI_LAST);
        is_lo = (code >= SURR_LO_FIRST) && (code <= SURR_LO_LAST);
        unit_bytes.delete();
        if (hi_pending && is_lo) begin
            emit_code_point(SUPP_BASE + {1'b0, held_hi_bits, 10'd0} + {11'd0, code[9:0]});
            hi_pending = 1'b0;
            held_hi_bits = 10'd0;
        end else begin
            if (hi_pending) begin
                emit_code_point({5'd0, SURR_HI_FIRST | {6'd0, held_hi_bits}});
                hi_pending = 1'b0;
                held_hi_bits = 10'd0;
            end
            if (is_hi && !last) begin
                held_hi_bits = code[9:0];
                hi_pending = 1'b1;
            end else begin
                emit_code_point({5'd0, code});
            end
        end
        if (unit_bytes.size() > 0) begin
            tail = unit_bytes.pop_back();
            tail.run_last = 1'b1;
            tail.string_end = last;
            unit_bytes.insert(unit_bytes.size(), tail);
        end
    endfunction

    function automatic void record_unit(input t_stim_row it);
        t_utf8_byte exp_byte;
        transcode_unit(it.code, it.last);
        if (it.nbytes < 0) begin
            foreach (unit_bytes[k]) utf8_expected.insert(utf8_expected.size(), unit_bytes[k]);
        end else begin
            for (int k = 0; k < it.nbytes; k++) begin
                exp_byte = '{data: it.bytes[47 - 8 * k -: 8],
                             run_last: (k == it.nbytes - 1),
                             string_end: (k == it.nbytes - 1) && it.last};
                utf8_expected.insert(utf8_expected.size(), exp_byte);
            end
        end
    endfunction

    function automatic void add_unit(input logic [15:0] code, input logic last);
        t_stim_row row;
        row = '{code, last, PREDICTED, 48'h0};
        stim_items.insert(stim_items.size(), row);
    endfunction

    // mostly well-formed strings, some broken surrogate use and raw noise
    function automatic void build_random_strings();
        logic [15:0] units[$];
        int          n_random;
        int          str_len;
        int          pick;
        n_random = 0;
        while (n_random < RANDOM_UNITS) begin
            units.delete();
            str_len = $urandom_range(1, 8);
            for (int k = 0; k < str_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    units.insert(units.size(), 16'($urandom_range(16'h0000, 16'h007F)));
                end else if (pick < 42) begin
                    units.insert(units.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
                end else if (pick < 60) begin
                    if ($urandom_range(0, 1) == 0)
                        units.insert(units.size(), 16'($urandom_range(16'h0800, 16'hD7FF)));
                    else
                        units.insert(units.size(), 16'($urandom_range(16'hE000, 16'hFFFF)));
                end else if (pick < 82) begin
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST)));
                end else if (pick < 88) begin
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
                end else if (pick < 94) begin
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST)));
                end else begin
                    units.insert(units.size(), 16'($urandom));
                end
            end
            foreach (units[k]) begin
                add_unit(units[k], k == units.size() - 1);
                n_random++;
            end
        end
    endfunction

    // output side: check accepted bytes, then stall on a mode that changes now and then
    int stall_mode = 0;
    int stall_phase_left = 0;
    int phase_tick = 0;

    always @(posedge i_clk) begin
        t_utf8_byte want;
        logic       stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (utf8_expected.size() == 0) begin
                $display("%0t: unexpected byte %h run_last %b string_end %b",
                         $time, o_out_byte, o_run_last, o_string_end);
                mismatches++;
            end else begin
                want = utf8_expected.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.data, o_out_byte);
                    mismatches++;
                end
                if (o_run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.run_last, o_run_last);
                    mismatches++;
                end
                if (o_string_end !== want.string_end) begin
                    $display("%0t: string_end expected %b actual %b",
                             $time, want.string_end, o_string_end);
                    mismatches++;
                end
            end
        end
        if (stall_phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(16, 80);
        end
        stall_phase_left--;
        phase_tick++;
        case (stall_mode)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 99) < 30);
            2:       stall_next = ($urandom_range(0, 99) < 70);
            default: stall_next = (phase_tick % 3 == 0);
        endcase
        i_out_stall <= stall_next;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // input side: bursts of units with random gaps between them
    initial begin
        int        burst_left;
        int        gap;
        t_stim_row it;
        foreach (directed_rows[k]) stim_items.insert(stim_items.size(), directed_rows[k]);
        build_random_strings();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = 0;
        for (int idx = 0; idx < stim_items.size(); idx++) begin
            it = stim_items[idx];
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            i_in_valid  <= 1'b1;
            i_code_unit <= it.code;
            i_last_unit <= it.last;
            do @(posedge i_clk); while (o_in_stall);
            record_unit(it);
            burst_left--;
        end
        i_in_valid <= 1'b0;

        while (utf8_expected.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ utf16_to_utf8_transcoder.f @@
sv/u16u8_pkg.sv
sv/u16u8_front.sv
sv/u16u8_queue.sv
sv/u16u8_back.sv
sv/utf16_to_utf8_transcoder.sv
sv/u16u8_checker.sv
dv/tb.sv
